FILE: hdl/nmtl_pkg.sv
// Shared types, widths and codes for the navmesh triangle locate/height block.
// Every module of the block imports this package; it depends on nothing else.
`timescale 1ns / 1ps

package nmtl_pkg;

  // Field widths
  localparam int COORD_BITS   = 16;
  localparam int INDEX_BITS   = 16;
  localparam int VERT_BITS    = 3 * COORD_BITS;
  localparam int CFG_IDX_BITS = 3;

  // Datapath widths, all derived from the coordinate width
  localparam int DW    = COORD_BITS + 1;        // coordinate difference
  localparam int PW    = 2 * DW;                // difference product
  localparam int NW    = 2 * COORD_BITS + 3;    // plane normal component
  localparam int SPLIT = DW;                    // low slice of the normal
  localparam int NHW   = NW - SPLIT;            // high slice of the normal
  localparam int PLW   = SPLIT + 1 + DW;        // low partial product
  localparam int PHW   = NHW + DW;              // high partial product
  localparam int TW    = NW + DW;               // one numerator term
  localparam int SW    = TW + 1;                // numerator sum
  localparam int MW    = SW;                    // numerator magnitude
  localparam int DMW   = NW;                    // divisor magnitude
  localparam int QB    = COORD_BITS + 2;        // quotient bits kept
  localparam int YW    = QB + 2;                // height before saturation

  // Register stages from accept to result: 3 geometry, 4 numerator,
  // 1 range check, QB divide steps, 2 rounding/saturation
  localparam int LATENCY = QB + 10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_VERTEX_A,
    REG_VERTEX_B,
    REG_VERTEX_C,
    REG_NB_AB,
    REG_NB_BC,
    REG_NB_CA
  } cfg_reg_e;

  // Edge codes
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;

  // Query modes
  localparam logic MODE_LOCATE = 1'b0;
  localparam logic MODE_SHARE  = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [INDEX_BITS-1:0] index_t;

  localparam index_t NB_NONE = '1;

  // Input transaction
  typedef struct packed {
    logic   mode;
    coord_t pos_x;
    coord_t pos_z;
    coord_t src_x;
    coord_t src_y;
    coord_t src_z;
    coord_t dst_x;
    coord_t dst_y;
    coord_t dst_z;
  } nmtl_in_t;

  // Result transaction
  typedef struct packed {
    logic       inside_res;
    logic [1:0] exit_edge;
    index_t     neighbour_out;
    coord_t     plane_height;
    logic       height_valid;
    logic       shares_edge;
  } nmtl_out_t;

  // Per-item control and finished fields that ride along the pipeline
  typedef struct packed {
    logic       vld;
    logic       mode;
    logic       share;
    logic       in_tri;
    logic [1:0] exit_edge;
    index_t     nb;
    coord_t     ay;
  } side_t;

  // Geometry stage output
  typedef struct packed {
    side_t                 side;
    logic signed [NW-1:0]  nx;
    logic signed [NW-1:0]  ny;
    logic signed [NW-1:0]  nz;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dz;
  } geo_t;

  // Numerator stage output
  typedef struct packed {
    side_t          side;
    logic [MW-1:0]  mag;
    logic [DMW-1:0] dmag;
    logic           neg;
    logic           ny_zero;
  } num_t;

  // Divider stage contents
  typedef struct packed {
    side_t          side;
    logic [MW-1:0]  rem;
    logic [DMW-1:0] dmag;
    logic [QB-1:0]  quo;
    logic           ovf;
    logic           neg;
    logic           ny_zero;
  } quo_t;

  // Sign-extend one coordinate to difference width
  function automatic logic signed [DW-1:0] coord_ext(logic [COORD_BITS-1:0] v);
    return {v[COORD_BITS-1], v};
  endfunction

endpackage

FILE: hdl/nmtl_geom.sv
// Geometry front end: edge differences, edge tests, plane normal, shared-edge match.
// Three register stages; uses nmtl_pkg.
`timescale 1ns / 1ps

module nmtl_geom (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  nmtl_pkg::nmtl_in_t               in_i,
  input  logic [nmtl_pkg::VERT_BITS-1:0]   vert_a_i,
  input  logic [nmtl_pkg::VERT_BITS-1:0]   vert_b_i,
  input  logic [nmtl_pkg::VERT_BITS-1:0]   vert_c_i,
  input  nmtl_pkg::index_t                 nb_ab_i,
  input  nmtl_pkg::index_t                 nb_bc_i,
  input  nmtl_pkg::index_t                 nb_ca_i,
  output nmtl_pkg::geo_t                   geo_o
);
  import nmtl_pkg::*;

  logic [VERT_BITS-1:0]  vraw [3];
  logic signed [DW-1:0]  vx [3];
  logic signed [DW-1:0]  vy [3];
  logic signed [DW-1:0]  vz [3];
  logic signed [DW-1:0]  px;
  logic signed [DW-1:0]  pz;
  logic [2:0]            src_hit;
  logic [2:0]            dst_hit;
  logic                  share;

  // Stage 1 registers
  side_t                 s1_side_q;
  logic signed [DW-1:0]  ex_q [3];
  logic signed [DW-1:0]  ez_q [3];
  logic signed [DW-1:0]  rx_q [3];
  logic signed [DW-1:0]  rz_q [3];
  logic signed [DW-1:0]  e1_q [3];
  logic signed [DW-1:0]  e2_q [3];
  logic signed [DW-1:0]  dxa_q;
  logic signed [DW-1:0]  dza_q;

  // Stage 2 registers
  side_t                 s2_side_q;
  logic signed [PW-1:0]  pa_q [3];
  logic signed [PW-1:0]  pb_q [3];
  logic signed [PW-1:0]  m_q [6];
  logic signed [DW-1:0]  s2_dx_q;
  logic signed [DW-1:0]  s2_dz_q;

  // Stage 3 register
  geo_t                  geo_q;
  geo_t                  geo_d;
  logic signed [PW:0]    t [3];
  logic [2:0]            out_hit;

  // Unpack vertices and query position
  always_comb begin
    vraw[0] = vert_a_i;
    vraw[1] = vert_b_i;
    vraw[2] = vert_c_i;
    for (int i = 0; i < 3; i++) begin
      vx[i] = coord_ext(vraw[i][COORD_BITS-1:0]);
      vy[i] = coord_ext(vraw[i][2*COORD_BITS-1:COORD_BITS]);
      vz[i] = coord_ext(vraw[i][3*COORD_BITS-1:2*COORD_BITS]);
    end
    px = coord_ext(in_i.pos_x);
    pz = coord_ext(in_i.pos_z);
  end

  // Match source and destination against the vertex slots
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      src_hit[i] = (vraw[i][COORD_BITS-1:0] == in_i.src_x) &&
                   (vraw[i][2*COORD_BITS-1:COORD_BITS] == in_i.src_y) &&
                   (vraw[i][3*COORD_BITS-1:2*COORD_BITS] == in_i.src_z);
      dst_hit[i] = (vraw[i][COORD_BITS-1:0] == in_i.dst_x) &&
                   (vraw[i][2*COORD_BITS-1:COORD_BITS] == in_i.dst_y) &&
                   (vraw[i][3*COORD_BITS-1:2*COORD_BITS] == in_i.dst_z);
    end
    share = (src_hit[0] && (dst_hit[1] || dst_hit[2])) ||
            (src_hit[1] && (dst_hit[0] || dst_hit[2])) ||
            (src_hit[2] && (dst_hit[0] || dst_hit[1]));
  end

  // Stage 1: take differences
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_side_q <= '0;
    end else begin
      s1_side_q.vld       <= in_valid_i;
      s1_side_q.mode      <= in_i.mode;
      s1_side_q.share     <= share;
      s1_side_q.in_tri    <= 1'b0;
      s1_side_q.exit_edge <= EDGE_AB;
      s1_side_q.nb        <= NB_NONE;
      s1_side_q.ay        <= vert_a_i[2*COORD_BITS-1:COORD_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ex_q[i] <= vx[(i + 1) % 3] - vx[i];
      ez_q[i] <= vz[(i + 1) % 3] - vz[i];
      rx_q[i] <= px - vx[i];
      rz_q[i] <= pz - vz[i];
    end
    e1_q[0] <= vx[1] - vx[0];
    e1_q[1] <= vy[1] - vy[0];
    e1_q[2] <= vz[1] - vz[0];
    e2_q[0] <= vx[2] - vx[0];
    e2_q[1] <= vy[2] - vy[0];
    e2_q[2] <= vz[2] - vz[0];
    dxa_q   <= vx[0] - px;
    dza_q   <= vz[0] - pz;
  end

  // Stage 2: multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_side_q <= '0;
    end else begin
      s2_side_q <= s1_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pa_q[i] <= ez_q[i] * rx_q[i];
      pb_q[i] <= ex_q[i] * rz_q[i];
    end
    m_q[0]  <= e1_q[1] * e2_q[2];
    m_q[1]  <= e1_q[2] * e2_q[1];
    m_q[2]  <= e1_q[2] * e2_q[0];
    m_q[3]  <= e1_q[0] * e2_q[2];
    m_q[4]  <= e1_q[0] * e2_q[1];
    m_q[5]  <= e1_q[1] * e2_q[0];
    s2_dx_q <= dxa_q;
    s2_dz_q <= dza_q;
  end

  // Stage 3: edge sums, first exit edge, normal components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i]       = pb_q[i] - pa_q[i];
      out_hit[i] = !t[i][PW] && (t[i] != '0);
    end
    geo_d      = '0;
    geo_d.side = s2_side_q;
    if (out_hit[0]) begin
      geo_d.side.exit_edge = EDGE_AB;
      geo_d.side.nb        = nb_ab_i;
    end else if (out_hit[1]) begin
      geo_d.side.exit_edge = EDGE_BC;
      geo_d.side.nb        = nb_bc_i;
    end else if (out_hit[2]) begin
      geo_d.side.exit_edge = EDGE_CA;
      geo_d.side.nb        = nb_ca_i;
    end else begin
      geo_d.side.in_tri    = 1'b1;
    end
    geo_d.nx = m_q[0] - m_q[1];
    geo_d.ny = m_q[2] - m_q[3];
    geo_d.nz = m_q[4] - m_q[5];
    geo_d.dx = s2_dx_q;
    geo_d.dz = s2_dz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geo_q <= '0;
    end else begin
      geo_q <= geo_d;
    end
  end

  assign geo_o = geo_q;

endmodule

FILE: hdl/nmtl_numer.sv
// Height numerator: n.x*(A.x-px) + n.z*(A.z-pz) as sign and magnitude, plus |n.y|.
// Four register stages with split partial products; uses nmtl_pkg.
`timescale 1ns / 1ps

module nmtl_numer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nmtl_pkg::geo_t  geo_i,
  output nmtl_pkg::num_t  num_o
);
  import nmtl_pkg::*;

  side_t                 s4_side_q;
  logic signed [PLW-1:0] plx_q;
  logic signed [PHW-1:0] phx_q;
  logic signed [PLW-1:0] plz_q;
  logic signed [PHW-1:0] phz_q;
  logic signed [NW-1:0]  s4_ny_q;

  side_t                 s5_side_q;
  logic signed [TW-1:0]  tx_q;
  logic signed [TW-1:0]  tz_q;
  logic signed [NW-1:0]  s5_ny_q;

  side_t                 s6_side_q;
  logic signed [SW-1:0]  sum_q;
  logic signed [NW-1:0]  s6_ny_q;

  num_t                  num_q;

  // Stage 4: partial products of the normal's low and high slices
  always_ff @(posedge clk_i) begin
    plx_q   <= $signed({1'b0, geo_i.nx[SPLIT-1:0]}) * geo_i.dx;
    phx_q   <= $signed(geo_i.nx[NW-1:SPLIT]) * geo_i.dx;
    plz_q   <= $signed({1'b0, geo_i.nz[SPLIT-1:0]}) * geo_i.dz;
    phz_q   <= $signed(geo_i.nz[NW-1:SPLIT]) * geo_i.dz;
    s4_ny_q <= geo_i.ny;
  end

  // Stage 5: recombine each product
  always_ff @(posedge clk_i) begin
    tx_q    <= (TW'(phx_q) <<< SPLIT) + TW'(plx_q);
    tz_q    <= (TW'(phz_q) <<< SPLIT) + TW'(plz_q);
    s5_ny_q <= s4_ny_q;
  end

  // Stage 6: add the two terms
  always_ff @(posedge clk_i) begin
    sum_q   <= SW'(tx_q) + SW'(tz_q);
    s6_ny_q <= s5_ny_q;
  end

  // Carry control along
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_side_q <= '0;
      s5_side_q <= '0;
      s6_side_q <= '0;
      num_q     <= '0;
    end else begin
      s4_side_q     <= geo_i.side;
      s5_side_q     <= s4_side_q;
      s6_side_q     <= s5_side_q;
      // Stage 7: magnitudes and quotient sign
      num_q.side    <= s6_side_q;
      num_q.mag     <= sum_q[SW-1] ? MW'(-sum_q) : MW'(sum_q);
      num_q.dmag    <= s6_ny_q[NW-1] ? DMW'(-s6_ny_q) : DMW'(s6_ny_q);
      num_q.neg     <= sum_q[SW-1] ^ s6_ny_q[NW-1];
      num_q.ny_zero <= (s6_ny_q == '0);
    end
  end

  assign num_o = num_q;

endmodule

FILE: hdl/nmtl_div.sv
// Pipelined restoring divider: range check, then one quotient bit per stage.
// QB + 1 register stages; uses nmtl_pkg.
`timescale 1ns / 1ps

module nmtl_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nmtl_pkg::num_t  num_i,
  output nmtl_pkg::quo_t  quo_o
);
  import nmtl_pkg::*;

  quo_t          stg_q [QB+1];
  quo_t          nxt [QB];
  logic [MW-1:0] dsh [QB];

  // One compare-subtract per stage against the shifted divisor
  always_comb begin
    for (int g = 0; g < QB; g++) begin
      dsh[g] = MW'(stg_q[g].dmag) << (QB - 1 - g);
      nxt[g] = stg_q[g];
      if (stg_q[g].rem >= dsh[g]) begin
        nxt[g].rem              = stg_q[g].rem - dsh[g];
        nxt[g].quo[QB - 1 - g]  = 1'b1;
      end
    end
  end

  // Stage 0 flags a quotient that cannot fit; the rest advance one bit each
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g <= QB; g++) begin
        stg_q[g] <= '0;
      end
    end else begin
      stg_q[0].side    <= num_i.side;
      stg_q[0].rem     <= num_i.mag;
      stg_q[0].dmag    <= num_i.dmag;
      stg_q[0].quo     <= '0;
      stg_q[0].ovf     <= (num_i.mag >= {num_i.dmag, {QB{1'b0}}});
      stg_q[0].neg     <= num_i.neg;
      stg_q[0].ny_zero <= num_i.ny_zero;
      for (int g = 0; g < QB; g++) begin
        stg_q[g+1] <= nxt[g];
      end
    end
  end

  assign quo_o = stg_q[QB];

endmodule

FILE: hdl/navmesh_triangle_locate_height.sv
// Top level of the navmesh triangle locate/height block: configuration registers,
// pipeline hookup, rounding and saturation; uses nmtl_pkg, nmtl_geom, nmtl_numer, nmtl_div.
//
//   channel   handshake                 payload        direction
//   -------   -----------------------   ------------   ---------
//   query     start / busy              in_i           in
//   result    result_valid_o (strobe)   result_o       out
//   config    cfg_we_i                  cfg_idx_i,     in
//                                       cfg_wdata_i
//
// A query is taken in every cycle; busy is never raised.
// Each result passes through the geometry and numerator stages, the bit-per-stage
// quotient pipeline of the plane height, and the rounding stages.
// Results leave in query order for one cycle each; the receiver cannot stall.
// Reset clears the valid bits of all stages, the vertices to zero, the neighbours to -1.
`timescale 1ns / 1ps

module navmesh_triangle_locate_height (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  nmtl_pkg::nmtl_in_t                 in_i,
  output logic                               result_valid_o,
  output nmtl_pkg::nmtl_out_t                result_o,
  input  logic                               cfg_we_i,
  input  logic [nmtl_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [nmtl_pkg::VERT_BITS-1:0]     cfg_wdata_i
);
  import nmtl_pkg::*;

  localparam logic signed [YW-1:0] Y_MAX = YW'((1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [YW-1:0] Y_MIN = ~Y_MAX;

  logic [VERT_BITS-1:0] vert_a_q;
  logic [VERT_BITS-1:0] vert_b_q;
  logic [VERT_BITS-1:0] vert_c_q;
  index_t               nb_ab_q;
  index_t               nb_bc_q;
  index_t               nb_ca_q;

  geo_t                 geo;
  num_t                 num;
  quo_t                 quo;

  side_t                f1_side_q;
  logic [QB:0]          f1_qf_q;
  logic                 f1_ovf_q;
  logic                 f1_neg_q;
  logic                 f1_nyz_q;
  logic                 rnd;

  logic signed [YW-1:0] ayw;
  logic signed [YW-1:0] qfw;
  logic signed [YW-1:0] yw;
  coord_t               hgt;
  nmtl_out_t            res_d;
  nmtl_out_t            res_q;
  logic                 res_vld_q;

  // Queries are never held off
  assign busy = 1'b0;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_a_q <= '0;
      vert_b_q <= '0;
      vert_c_q <= '0;
      nb_ab_q  <= NB_NONE;
      nb_bc_q  <= NB_NONE;
      nb_ca_q  <= NB_NONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VERTEX_A: vert_a_q <= cfg_wdata_i;
        REG_VERTEX_B: vert_b_q <= cfg_wdata_i;
        REG_VERTEX_C: vert_c_q <= cfg_wdata_i;
        REG_NB_AB:    nb_ab_q  <= cfg_wdata_i[INDEX_BITS-1:0];
        REG_NB_BC:    nb_bc_q  <= cfg_wdata_i[INDEX_BITS-1:0];
        REG_NB_CA:    nb_ca_q  <= cfg_wdata_i[INDEX_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  nmtl_geom u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start && !busy),
    .in_i       (in_i),
    .vert_a_i   (vert_a_q),
    .vert_b_i   (vert_b_q),
    .vert_c_i   (vert_c_q),
    .nb_ab_i    (nb_ab_q),
    .nb_bc_i    (nb_bc_q),
    .nb_ca_i    (nb_ca_q),
    .geo_o      (geo)
  );

  nmtl_numer u_numer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .geo_i  (geo),
    .num_o  (num)
  );

  nmtl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .num_i  (num),
    .quo_o  (quo)
  );

  // Round half away from zero on the magnitude
  assign rnd = ({quo.rem, 1'b0} >= (MW + 1)'(quo.dmag));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_side_q <= '0;
    end else begin
      f1_side_q <= quo.side;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_qf_q  <= {1'b0, quo.quo} + (QB + 1)'(rnd);
    f1_ovf_q <= quo.ovf;
    f1_neg_q <= quo.neg;
    f1_nyz_q <= quo.ny_zero;
  end

  // Offset from vertex A height and saturate
  always_comb begin
    ayw = $signed({{(YW - COORD_BITS){f1_side_q.ay[COORD_BITS-1]}}, f1_side_q.ay});
    qfw = $signed(YW'(f1_qf_q));
    yw  = f1_neg_q ? (ayw - qfw) : (ayw + qfw);
    if (f1_ovf_q) begin
      hgt = f1_neg_q ? Y_MIN[COORD_BITS-1:0] : Y_MAX[COORD_BITS-1:0];
    end else if (yw > Y_MAX) begin
      hgt = Y_MAX[COORD_BITS-1:0];
    end else if (yw < Y_MIN) begin
      hgt = Y_MIN[COORD_BITS-1:0];
    end else begin
      hgt = yw[COORD_BITS-1:0];
    end
  end

  // Assemble the result by mode
  always_comb begin
    res_d = '0;
    if (f1_side_q.mode == MODE_SHARE) begin
      res_d.neighbour_out = NB_NONE;
      res_d.shares_edge   = f1_side_q.share;
    end else begin
      res_d.inside_res    = f1_side_q.in_tri;
      res_d.exit_edge     = f1_side_q.exit_edge;
      res_d.neighbour_out = f1_side_q.nb;
      res_d.height_valid  = !f1_nyz_q;
      res_d.plane_height  = f1_nyz_q ? '0 : hgt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= f1_side_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

FILE: hdl/nmtl_checker.sv
// Port-level checks for the navmesh triangle locate/height block, bound to its top level.
// Uses nmtl_pkg for the latency, edge codes and the empty neighbour code.
`timescale 1ns / 1ps

module nmtl_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 result_valid_o,
  input nmtl_pkg::nmtl_out_t  result_o
);
  import nmtl_pkg::*;

  localparam int CW = $clog2(LATENCY + 1);

  logic [CW-1:0] warm_q;
  logic          warm;
  logic          accept;

  assign warm   = (warm_q == CW'(LATENCY));
  assign accept = start && !busy;

  // Count cycles since reset so the latency check looks only at real history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (!warm) begin
      warm_q <= warm_q + CW'(1);
    end
  end

  // Every accepted transaction yields exactly one result a fixed time later
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm |-> (result_valid_o == $past(accept, LATENCY)))
    else $error("result strobe does not match accepted query");

  // A shared-edge hit carries the neutral locate fields
  a_share_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.shares_edge) |->
      (!result_o.inside_res && !result_o.height_valid &&
       result_o.neighbour_out == NB_NONE && result_o.plane_height == '0))
    else $error("shared-edge result with locate fields set");

  // Inside means no exit edge and no neighbour
  a_inside_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.inside_res) |->
      (result_o.exit_edge == EDGE_AB && result_o.neighbour_out == NB_NONE &&
       !result_o.shares_edge))
    else $error("inside result with exit information");

  // No height is reported without a valid plane
  a_height_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.height_valid) |-> (result_o.plane_height == '0))
    else $error("height given for an invalid plane");

endmodule

bind navmesh_triangle_locate_height nmtl_checker u_nmtl_checker (.*);

FILE: bench/navmesh_triangle_locate_height_tb.sv
// Self-checking bench for navmesh_triangle_locate_height: directed and random
// triangles and queries, each result checked against an in-bench predictor.
// Depends on nmtl_pkg and the navmesh_triangle_locate_height RTL only.
`timescale 1ns / 1ps

module navmesh_triangle_locate_height_tb;
  import nmtl_pkg::*;

  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     RAND_PHASES    = 11;
  localparam int     PHASE_ITEMS    = 75;
  localparam int     PRESSURE_PHASE = 4;
  localparam longint QUO_CAP        = 64'sh100_0000_0000;
  localparam longint COORD_MAX      = 32767;
  localparam longint COORD_MIN      = -32768;

  // Register indexes past the last register; writes to them must be ignored
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;

  // Coordinate slots inside a packed vertex word
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  typedef enum {TRI_LOCAL, TRI_WIDE, TRI_COLLAPSED, TRI_UPRIGHT} tri_style_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  nmtl_in_t                in_i;
  logic                    result_valid_o;
  nmtl_out_t               result_o;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [VERT_BITS-1:0]    cfg_wdata_i;

  // Mirror of the triangle registers
  logic [VERT_BITS-1:0] vert_word [3];
  index_t               nb_word   [3];

  nmtl_out_t lookups_due [$];
  nmtl_out_t want_res;
  int        mismatch_cnt;
  int        quiet_cycles;
  int        burst_left;

  navmesh_triangle_locate_height uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint coord_val(logic [COORD_BITS-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint vertex_axis(int k, int axis);
    return coord_val(vert_word[k][axis*COORD_BITS +: COORD_BITS]);
  endfunction

  function automatic logic [VERT_BITS-1:0] pack_vertex(int x, int y, int z);
    return {coord_t'(z), coord_t'(y), coord_t'(x)};
  endfunction

  // Edge exits, plane height and shared-edge match for one query
  function automatic nmtl_out_t lookup_result(nmtl_in_t q);
    nmtl_out_t r;
    longint    vx [3];
    longint    vy [3];
    longint    vz [3];
    longint    px, pz, ex, ez, t;
    longint    nx, ny, nz, num, mag, den, quo, rmd, y;
    int        k, j;
    r = '0;
    r.neighbour_out = NB_NONE;
    for (k = 0; k < 3; k++) begin
      vx[k] = vertex_axis(k, AXIS_X);
      vy[k] = vertex_axis(k, AXIS_Y);
      vz[k] = vertex_axis(k, AXIS_Z);
    end
    if (q.mode == MODE_LOCATE) begin
      px = coord_val(q.pos_x);
      pz = coord_val(q.pos_z);
      r.inside_res = 1'b1;
      // Report the first edge that the position lies beyond
      for (k = 0; k < 3; k++) begin
        j  = (k == 2) ? 0 : k + 1;
        ex = vx[j] - vx[k];
        ez = vz[j] - vz[k];
        t  = -ez * (px - vx[k]) + ex * (pz - vz[k]);
        if (t > 0 && r.inside_res) begin
          r.inside_res    = 1'b0;
          r.neighbour_out = nb_word[k];
          case (k)
            0:       r.exit_edge = EDGE_AB;
            1:       r.exit_edge = EDGE_BC;
            default: r.exit_edge = EDGE_CA;
          endcase
        end
      end
      // Plane height from the exact normal, rounded half away from zero
      nx = (vy[1] - vy[0]) * (vz[2] - vz[0]) - (vz[1] - vz[0]) * (vy[2] - vy[0]);
      ny = (vz[1] - vz[0]) * (vx[2] - vx[0]) - (vx[1] - vx[0]) * (vz[2] - vz[0]);
      nz = (vx[1] - vx[0]) * (vy[2] - vy[0]) - (vy[1] - vy[0]) * (vx[2] - vx[0]);
      if (ny != 0) begin
        num = nx * (vx[0] - px) + nz * (vz[0] - pz);
        mag = (num < 0) ? -num : num;
        den = (ny < 0) ? -ny : ny;
        quo = mag / den;
        rmd = mag % den;
        if (quo > QUO_CAP) quo = QUO_CAP;
        if (2 * rmd >= den) quo = quo + 1;
        y = vy[0] + (((num < 0) != (ny < 0)) ? -quo : quo);
        if (y > COORD_MAX) y = COORD_MAX;
        if (y < COORD_MIN) y = COORD_MIN;
        r.plane_height = coord_t'(y[COORD_BITS-1:0]);
        r.height_valid = 1'b1;
      end
    end else begin
      // Source on one vertex slot, destination on a different one
      for (k = 0; k < 3; k++) begin
        if (vx[k] == coord_val(q.src_x) && vy[k] == coord_val(q.src_y) &&
            vz[k] == coord_val(q.src_z)) begin
          for (j = 0; j < 3; j++) begin
            if (j != k && vx[j] == coord_val(q.dst_x) && vy[j] == coord_val(q.dst_y) &&
                vz[j] == coord_val(q.dst_z))
              r.shares_edge = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic nmtl_in_t random_item();
    return nmtl_in_t'(145'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()}));
  endfunction

  function automatic nmtl_in_t locate_item(coord_t px, coord_t pz);
    nmtl_in_t q;
    q       = random_item();
    q.mode  = MODE_LOCATE;
    q.pos_x = px;
    q.pos_z = pz;
    return q;
  endfunction

  function automatic nmtl_in_t share_item(coord_t sx, coord_t sy, coord_t sz,
                                          coord_t dx, coord_t dy, coord_t dz);
    nmtl_in_t q;
    q       = random_item();
    q.mode  = MODE_SHARE;
    q.src_x = sx;
    q.src_y = sy;
    q.src_z = sz;
    q.dst_x = dx;
    q.dst_y = dy;
    q.dst_z = dz;
    return q;
  endfunction

  function automatic coord_t near_coord(int c, int reach);
    int off;
    off = int'($urandom_range(0, 2 * reach)) - reach;
    return coord_t'(c + off);
  endfunction

  function automatic logic [VERT_BITS-1:0] near_vertex(int cx, int cy, int cz, int reach);
    return {near_coord(cz, reach), near_coord(cy, reach), near_coord(cx, reach)};
  endfunction

  function automatic index_t random_neighbour();
    case ($urandom_range(0, 3))
      0:       return NB_NONE;
      1:       return index_t'(16'h7fff);
      2:       return index_t'(0);
      default: return index_t'($urandom_range(0, 32767));
    endcase
  endfunction

  // Drive one query at the falling edge and hold it until accepted
  task automatic send_query(input nmtl_in_t q);
    start <= 1'b1;
    in_i  <= q;
    do @(posedge clk_i); while (busy);
    lookups_due.push_back(lookup_result(q));
    @(negedge clk_i);
  endtask

  // Insert a random gap once the current burst is used up
  task automatic pace_sender(input bit steady);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    start <= 1'b0;
    while (lookups_due.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Write one register; the caller lowers the write enable after the last one
  task automatic cfg_put(input logic [CFG_IDX_BITS-1:0] idx, input logic [VERT_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx <= REG_VERTEX_C)
      vert_word[idx] = data;
    else if (idx <= REG_NB_CA)
      nb_word[idx - REG_NB_AB] = index_t'(data[INDEX_BITS-1:0]);
    @(negedge clk_i);
  endtask

  task automatic load_triangle(input logic [VERT_BITS-1:0] va, vb, vc,
                               input index_t nab, nbc, nca);
    drain_results();
    cfg_put(REG_VERTEX_A, va);
    cfg_put(REG_VERTEX_B, vb);
    cfg_put(REG_VERTEX_C, vc);
    cfg_put(REG_NB_AB, VERT_BITS'(nab));
    cfg_put(REG_NB_BC, VERT_BITS'(nbc));
    cfg_put(REG_NB_CA, VERT_BITS'(nca));
    cfg_we_i <= 1'b0;
  endtask

  // Reset values: every vertex at the origin, no neighbours
  task automatic test_reset_state();
    send_query(locate_item(-32768, 32767));
    send_query(share_item(0, 0, 0, 0, 0, 0));
  endtask

  // Inside, boundary, each exit edge and three corners of the position range
  task automatic test_exit_edges();
    load_triangle(pack_vertex(0, 16, 0), pack_vertex(0, 32, 160), pack_vertex(160, 48, 0),
                  index_t'(11), index_t'(22), index_t'(33));
    send_query(locate_item(32, 32));
    send_query(locate_item(0, 50));
    send_query(locate_item(-16, 32));
    send_query(locate_item(150, 150));
    send_query(locate_item(32, -16));
    send_query(locate_item(-32768, -32768));
    send_query(locate_item(32767, 32767));
    send_query(locate_item(32767, -32768));
  endtask

  // Vertical plane, rounding of exact halves, quotient cap and saturation
  task automatic test_plane_height();
    load_triangle(pack_vertex(0, 0, 0), pack_vertex(160, 16, 0), pack_vertex(80, 32, 0),
                  NB_NONE, index_t'(1), index_t'(2));
    send_query(locate_item(40, 0));
    send_query(locate_item(40, 5));
    load_triangle(pack_vertex(0, 0, 0), pack_vertex(0, 1, 2), pack_vertex(1, 0, 0),
                  index_t'(3), NB_NONE, index_t'(4));
    send_query(locate_item(0, 1));
    send_query(locate_item(0, -1));
    send_query(locate_item(0, 3));
    load_triangle(pack_vertex(-32768, -32768, -32768), pack_vertex(-32768, 32767, -32767),
                  pack_vertex(-32767, -32768, 32767), index_t'(5), index_t'(6), index_t'(7));
    send_query(locate_item(32767, 0));
    send_query(locate_item(-32768, 32767));
  endtask

  // Shared-edge matches in both directions, same slot twice, near misses
  task automatic test_shared_edge();
    load_triangle(pack_vertex(16, 32, 48), pack_vertex(-16, -32, -48), pack_vertex(100, -1, 5),
                  index_t'(8), index_t'(9), index_t'(10));
    send_query(share_item(16, 32, 48, -16, -32, -48));
    send_query(share_item(100, -1, 5, 16, 32, 48));
    send_query(share_item(16, 32, 48, 16, 32, 48));
    send_query(share_item(16, 32, 48, -16, -31, -48));
    send_query(share_item(-16, -32, -47, 100, -1, 5));
  endtask

  // Spare indexes, bits above the register width, neighbour extremes
  task automatic test_register_edges();
    drain_results();
    cfg_put(REG_SPARE_6, '1);
    cfg_put(REG_SPARE_7, '1);
    cfg_put(REG_NB_AB, 48'hffff_ffff_7fff);
    cfg_put(REG_NB_BC, 48'h0);
    cfg_put(REG_NB_CA, 48'hffff_ffff_ffff);
    cfg_put(REG_VERTEX_A, '1);
    cfg_we_i <= 1'b0;
    send_query(locate_item(-32768, -32768));
    send_query(locate_item(32767, 32767));
    send_query(locate_item(0, 32767));
  endtask

  // Random triangles, each followed by a run of random queries around it
  task automatic test_random_triangles();
    int                   ph, n, pick, reach, cx, cy, cz, i, j;
    tri_style_e           style;
    logic [VERT_BITS-1:0] va, vb, vc;
    coord_t               tip [6];
    nmtl_in_t             q;
    bit                   steady;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      pick  = $urandom_range(0, 9);
      style = (pick < 6) ? TRI_LOCAL : (pick < 8) ? TRI_WIDE :
              (pick == 8) ? TRI_COLLAPSED : TRI_UPRIGHT;
      reach = 16 << $urandom_range(0, 7);
      cx    = int'($urandom_range(0, 58000)) - 29000;
      cy    = int'($urandom_range(0, 58000)) - 29000;
      cz    = int'($urandom_range(0, 58000)) - 29000;
      va    = near_vertex(cx, cy, cz, reach);
      vb    = near_vertex(cx, cy, cz, reach);
      vc    = near_vertex(cx, cy, cz, reach);
      case (style)
        TRI_WIDE: begin
          va = {16'($urandom()), 32'($urandom())};
          vb = {16'($urandom()), 32'($urandom())};
          vc = {16'($urandom()), 32'($urandom())};
        end
        TRI_COLLAPSED: vb = va;
        TRI_UPRIGHT: begin
          vb[2*COORD_BITS +: COORD_BITS] = va[2*COORD_BITS +: COORD_BITS];
          vc[2*COORD_BITS +: COORD_BITS] = va[2*COORD_BITS +: COORD_BITS];
        end
        default: ;
      endcase
      load_triangle(va, vb, vc, random_neighbour(), random_neighbour(), random_neighbour());
      steady = (ph % 3 == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Hold off once until the pipeline is empty
        if (ph == PRESSURE_PHASE && n == PHASE_ITEMS / 2) drain_results();
        pace_sender(steady);
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
          q = random_item();
        end else if (pick < 14) begin
          if (style == TRI_WIDE)
            q = locate_item(coord_t'($urandom()), coord_t'($urandom()));
          else
            q = locate_item(near_coord(cx, reach + reach / 2), near_coord(cz, reach + reach / 2));
        end else begin
          i = $urandom_range(0, 2);
          j = $urandom_range(0, 2);
          tip[0] = coord_t'(vertex_axis(i, AXIS_X));
          tip[1] = coord_t'(vertex_axis(i, AXIS_Y));
          tip[2] = coord_t'(vertex_axis(i, AXIS_Z));
          tip[3] = coord_t'(vertex_axis(j, AXIS_X));
          tip[4] = coord_t'(vertex_axis(j, AXIS_Y));
          tip[5] = coord_t'(vertex_axis(j, AXIS_Z));
          if ($urandom_range(0, 3) == 0)
            tip[$urandom_range(0, 5)] ^= coord_t'(1 << $urandom_range(0, COORD_BITS - 1));
          q = share_item(tip[0], tip[1], tip[2], tip[3], tip[4], tip[5]);
        end
        send_query(q);
      end
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatch_cnt++;
    end
  endtask

  // Match each result transaction against the oldest outstanding lookup
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (lookups_due.size() == 0) begin
        $error("result transaction with no query outstanding");
        mismatch_cnt++;
      end else begin
        want_res = lookups_due.pop_front();
        check_field("inside_res", want_res.inside_res, result_o.inside_res);
        check_field("exit_edge", want_res.exit_edge, result_o.exit_edge);
        check_field("neighbour_out", want_res.neighbour_out, result_o.neighbour_out);
        check_field("plane_height", want_res.plane_height, result_o.plane_height);
        check_field("height_valid", want_res.height_valid, result_o.height_valid);
        check_field("shares_edge", want_res.shares_edge, result_o.shares_edge);
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("navmesh_triangle_locate_height_tb: errors");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    in_i         = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    mismatch_cnt = 0;
    quiet_cycles = 0;
    burst_left   = 0;
    for (int k = 0; k < 3; k++) begin
      vert_word[k] = '0;
      nb_word[k]   = NB_NONE;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_exit_edges();
    test_plane_height();
    test_shared_edge();
    test_register_edges();
    test_random_triangles();

    // Let stragglers surface before the verdict
    drain_results();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("navmesh_triangle_locate_height_tb: clean");
    else
      $display("navmesh_triangle_locate_height_tb: errors");
    $finish;
  end

endmodule
